// File: src/trpf_pkg.sv
// Shared types, constants and the CRC helper for the thermal row packet framer.
package trpf_pkg;

   // Field widths and packing constants.
   localparam int PIXEL_W        = 16;
   localparam int QUOT_W         = 10;
   localparam int LANES          = 4;
   localparam int BYTES_PER_QUAD = 5;
   localparam int HDR_BYTES      = 5;
   localparam int BUF_BYTES      = HDR_BYTES + BYTES_PER_QUAD;
   localparam int LEFT_W         = $clog2(BUF_BYTES + 1);

   // Divide by five as a multiply by a reciprocal; exact for all 16-bit inputs.
   localparam logic [16:0] DIV5_MUL   = 17'd52429;
   localparam int          DIV5_SHIFT = 18;

   // CRC-8, reflected form, polynomial 0x8C, starting from zero.
   localparam logic [7:0] CRC_POLY = 8'h8C;

   // Register reset values.
   localparam logic [7:0] START_MARKER_RESET = 8'hFE;
   localparam logic [7:0] PACKET_TYPE_RESET  = 8'hCC;

   // Configuration register indexes.
   localparam int         CSR_INDEX_W      = 1;
   localparam logic [0:0] CSR_START_MARKER = 1'b0;
   localparam logic [0:0] CSR_PACKET_TYPE  = 1'b1;

   // One input word: a pixel quad plus the header fields.
   typedef struct packed {
      logic [7:0]         group_id;
      logic [15:0]        frame_seq;
      logic [PIXEL_W-1:0] pixel_0;
      logic [PIXEL_W-1:0] pixel_1;
      logic [PIXEL_W-1:0] pixel_2;
      logic [PIXEL_W-1:0] pixel_3;
   } req_type;

   // One output word: a packet byte and the end-of-packet flag.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       packet_end;
   } rsp_type;

   // Header bytes captured with each accepted quad and used with the first quad of a packet.
   typedef struct packed {
      logic [7:0]  start_marker;
      logic [7:0]  packet_type;
      logic [7:0]  group_id;
      logic [15:0] frame_seq;
   } hdr_type;

   // Control of the staged quad handed to the merge stage.
   typedef struct packed {
      logic valid;
      logic header;
      logic tail;
   } stage_ctl_type;

   // Quotients of all lanes.
   typedef logic [LANES-1:0][QUOT_W-1:0] quad_type;

   // Feeds one byte into the reflected CRC, least significant bit first.
   function automatic logic [7:0] crc_feed(input logic [7:0] crc_in, input logic [7:0] data);
      logic [7:0] crc;
      logic       mix;
      crc = crc_in;
      for (int k = 0; k < 8; k++) begin
         mix = crc[0] ^ data[k];
         crc = crc >> 1;
         if (mix) begin
            crc = crc ^ CRC_POLY;
         end
      end
      return crc;
   endfunction

endpackage

// File: src/trpf_lane.sv
// One pixel lane: divide by five, keep ten bits, zero the pixels past the array.
module trpf_lane (
   input  logic                          clock,
   input  logic                          load,
   input  logic                          blank,
   input  logic [trpf_pkg::PIXEL_W-1:0]  pixel,
   output logic [trpf_pkg::QUOT_W-1:0]   quot_ff
);

   logic [trpf_pkg::PIXEL_W+16:0] prod;
   logic [trpf_pkg::QUOT_W-1:0]   quot_in;

   // Reciprocal multiply; the quotient sits above the shift point.
   always_comb begin
      prod    = (trpf_pkg::PIXEL_W + 17)'(pixel) * (trpf_pkg::PIXEL_W + 17)'(trpf_pkg::DIV5_MUL);
      quot_in = blank ? '0
                      : prod[trpf_pkg::DIV5_SHIFT +: trpf_pkg::QUOT_W];
   end

   // Quotient register, loaded when a word is accepted.
   always_ff @(posedge clock) begin
      if (load) begin
         quot_ff <= quot_in;
      end
   end

endmodule

// File: src/trpf_merge.sv
// Merge stage: packs the lane quotients behind the header and sends bytes with the CRC.
module trpf_merge (
   input  logic                clock,
   input  logic                reset,
   input  trpf_pkg::stage_ctl_type stg,
   input  trpf_pkg::hdr_type   hdr,
   input  trpf_pkg::quad_type  quad,
   output logic                stg_take,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output trpf_pkg::rsp_type   rsp_data
);

   logic [7:0]                    buf_ff [trpf_pkg::BUF_BYTES];
   logic [7:0]                    buf_in [trpf_pkg::BUF_BYTES];
   logic [trpf_pkg::LEFT_W-1:0]   left_ff;
   logic [trpf_pkg::LEFT_W-1:0]   left_in;
   logic                          tail_ff;
   logic                          tail_in;
   logic [7:0]                    crc_ff;
   logic [7:0]                    crc_in;
   logic [8*trpf_pkg::BYTES_PER_QUAD-1:0] packed_bits;
   logic [7:0]                    data_byte [trpf_pkg::BYTES_PER_QUAD];
   logic                          crc_slot;
   logic                          fire;
   logic                          can_load;

   // The four ten-bit values, first lane most significant, cut into bytes.
   always_comb begin
      packed_bits = {quad[0], quad[1], quad[2], quad[3]};
      for (int i = 0; i < trpf_pkg::BYTES_PER_QUAD; i++) begin
         data_byte[i] = packed_bits[8*(trpf_pkg::BYTES_PER_QUAD-1-i) +: 8];
      end
   end

   // Output side: the CRC byte closes the packet.
   always_comb begin
      rsp_valid           = (left_ff != '0);
      crc_slot            = tail_ff && (left_ff == trpf_pkg::LEFT_W'(1));
      rsp_data.out_byte   = crc_slot ? crc_ff : buf_ff[0];
      rsp_data.packet_end = crc_slot;
      fire                = rsp_valid && !rsp_stall;
      can_load            = (left_ff == '0) || ((left_ff == trpf_pkg::LEFT_W'(1)) && fire);
      stg_take            = stg.valid && can_load;
   end

   // Next state of the byte buffer, count and CRC.
   always_comb begin
      buf_in  = buf_ff;
      left_in = left_ff;
      tail_in = tail_ff;
      crc_in  = crc_ff;
      if (fire) begin
         for (int i = 0; i < trpf_pkg::BUF_BYTES - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
         left_in = left_ff - trpf_pkg::LEFT_W'(1);
         crc_in  = crc_slot ? 8'h00 : trpf_pkg::crc_feed(crc_ff, buf_ff[0]);
      end
      if (stg_take) begin
         tail_in = stg.tail;
         if (stg.header) begin
            buf_in[0] = hdr.start_marker;
            buf_in[1] = hdr.packet_type;
            buf_in[2] = hdr.group_id;
            buf_in[3] = hdr.frame_seq[7:0];
            buf_in[4] = hdr.frame_seq[15:8];
            for (int i = 0; i < trpf_pkg::BYTES_PER_QUAD; i++) begin
               buf_in[trpf_pkg::HDR_BYTES + i] = data_byte[i];
            end
            left_in = trpf_pkg::LEFT_W'(trpf_pkg::BUF_BYTES);
         end else begin
            for (int i = 0; i < trpf_pkg::BYTES_PER_QUAD; i++) begin
               buf_in[i]                            = data_byte[i];
               buf_in[trpf_pkg::HDR_BYTES + i]      = data_byte[i];
            end
            left_in = stg.tail ? trpf_pkg::LEFT_W'(trpf_pkg::BYTES_PER_QUAD + 1)
                               : trpf_pkg::LEFT_W'(trpf_pkg::BYTES_PER_QUAD);
         end
      end
   end

   // Byte buffer holds header and payload bytes.
   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   // Control state of the serializer.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         tail_ff <= 1'b0;
         crc_ff  <= 8'h00;
      end else begin
         left_ff <= left_in;
         tail_ff <= tail_in;
         crc_ff  <= crc_in;
      end
   end

endmodule

// File: src/thermal_row_packet_framer.sv
// Top level of the thermal row packet framer: quad tracking, pixel lanes and merge stage.
//
//   channel  ports                                  direction  word
//   req      req_valid, req_stall, req_data         in         one pixel quad
//   rsp      rsp_valid, rsp_stall, rsp_data         out        one packet byte
//   csr      csr_wr_en, csr_index, csr_wdata        in         one register write
//
// An accepted quad is held in the lane registers until it loads the byte buffer, which
// sends one byte per cycle while the output is not stalled: ten bytes for the first quad
// of a packet, six for the last and five otherwise, so the byte output sets the rate.
// The next quad is accepted while the buffer still drains; a stalled output holds the
// buffer and, once the lane stage is full, stalls the input. Reset is synchronous; it
// clears the packet position and the CRC and empties the lane stage and the byte buffer.
module thermal_row_packet_framer #(
   parameter int unsigned PIXEL_COUNT     = 768,
   parameter int unsigned ROW_WIDTH       = 32,
   parameter int unsigned ROWS_PER_PACKET = 3
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  trpf_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output trpf_pkg::rsp_type                  rsp_data,
   input  logic                               csr_wr_en,
   input  logic [trpf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [7:0]                         csr_wdata
);

   localparam int QPR    = ROW_WIDTH / 4;
   localparam int COL_W  = (QPR > 1) ? $clog2(QPR) : 1;
   localparam int ROW_W  = (ROWS_PER_PACKET > 1) ? $clog2(ROWS_PER_PACKET) : 1;
   localparam int P_W    = $clog2(256 * ROWS_PER_PACKET * ROW_WIDTH);
   localparam int PC_W   = $clog2(PIXEL_COUNT + 1);
   localparam int CMP_W  = (P_W > PC_W) ? P_W : PC_W;

   logic [7:0]            start_marker_ff;
   logic [7:0]            packet_type_ff;
   logic [COL_W-1:0]      col_ff;
   logic [COL_W-1:0]      col_in;
   logic [ROW_W-1:0]      row_ff;
   logic [ROW_W-1:0]      row_in;
   logic [7:0]            held_group_ff;
   logic [7:0]            group_sel;
   logic                  first_quad;
   logic                  last_quad;
   logic                  col_wrap;
   logic [P_W-1:0]        row_num;
   logic [P_W-1:0]        last_pix;
   logic                  blank;
   logic                  accept;
   logic                  stg_take;
   trpf_pkg::stage_ctl_type stg_ff;
   trpf_pkg::stage_ctl_type stg_in;
   trpf_pkg::hdr_type     hdr_ff;
   trpf_pkg::quad_type    quad;
   logic [trpf_pkg::PIXEL_W-1:0] pix [trpf_pkg::LANES];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= trpf_pkg::START_MARKER_RESET;
         packet_type_ff  <= trpf_pkg::PACKET_TYPE_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == trpf_pkg::CSR_START_MARKER) begin
            start_marker_ff <= csr_wdata;
         end
         if (csr_index == trpf_pkg::CSR_PACKET_TYPE) begin
            packet_type_ff <= csr_wdata;
         end
      end
   end

   // Packet position and the out-of-array check for the quad being accepted.
   always_comb begin
      first_quad = (row_ff == '0) && (col_ff == '0);
      col_wrap   = (col_ff == COL_W'(QPR - 1));
      last_quad  = col_wrap && (row_ff == ROW_W'(ROWS_PER_PACKET - 1));
      group_sel  = first_quad ? req_data.group_id : held_group_ff;
      row_num    = P_W'(group_sel) * P_W'(ROWS_PER_PACKET) + P_W'(row_ff);
      last_pix   = row_num * P_W'(ROW_WIDTH) + (P_W'(col_ff) << 2) + P_W'(3);
      blank      = CMP_W'(last_pix) >= CMP_W'(PIXEL_COUNT);
      req_stall  = stg_ff.valid && !stg_take;
      accept     = req_valid && !req_stall;
      col_in     = col_wrap ? '0 : col_ff + COL_W'(1);
      row_in     = last_quad ? '0 : (col_wrap ? row_ff + ROW_W'(1) : row_ff);
      stg_in.valid  = accept || (stg_ff.valid && !stg_take);
      stg_in.header = accept ? first_quad : stg_ff.header;
      stg_in.tail   = accept ? last_quad : stg_ff.tail;
   end

   // Control state: packet position, held group and the lane stage flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         held_group_ff <= 8'h00;
         stg_ff        <= '0;
      end else begin
         stg_ff <= stg_in;
         if (accept) begin
            col_ff        <= col_in;
            row_ff        <= row_in;
            held_group_ff <= group_sel;
         end
      end
   end

   // Header bytes ride along with the staged quad.
   always_ff @(posedge clock) begin
      if (accept) begin
         hdr_ff.start_marker <= start_marker_ff;
         hdr_ff.packet_type  <= packet_type_ff;
         hdr_ff.group_id     <= req_data.group_id;
         hdr_ff.frame_seq    <= req_data.frame_seq;
      end
   end

   // Pixels of the quad in lane order.
   always_comb begin
      pix[0] = req_data.pixel_0;
      pix[1] = req_data.pixel_1;
      pix[2] = req_data.pixel_2;
      pix[3] = req_data.pixel_3;
   end

   // Four pixel lanes work side by side.
   for (genvar g = 0; g < trpf_pkg::LANES; g++) begin : g_lane
      trpf_lane u_lane (
         .clock   (clock),
         .load    (accept),
         .blank   (blank),
         .pixel   (pix[g]),
         .quot_ff (quad[g])
      );
   end

   // Merge stage and byte output.
   trpf_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .stg       (stg_ff),
      .hdr       (hdr_ff),
      .quad      (quad),
      .stg_take  (stg_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: tb/tb_thermal_row_packet_framer.sv
// Self-checking testbench for the thermal row packet framer: random quads, byte checks, CRC.
module tb_thermal_row_packet_framer;

   localparam int unsigned PIXEL_COUNT     = 768;
   localparam int unsigned ROW_WIDTH       = 32;
   localparam int unsigned ROWS_PER_PACKET = 3;
   localparam int unsigned QUADS_PER_ROW   = ROW_WIDTH / 4;
   localparam int unsigned QUADS           = ROWS_PER_PACKET * QUADS_PER_ROW;
   localparam int          MAX_WAIT        = 18;
   localparam int          DRAIN_CYCLES    = 8;
   localparam int          CYCLE_LIMIT     = 400000;
   localparam int          REPORT_LIMIT    = 10;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   trpf_pkg::req_type      req_data    = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   trpf_pkg::rsp_type      rsp_data;
   logic                   csr_wr_en   = 1'b0;
   logic [trpf_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0]             csr_wdata   = '0;

   // Quads waiting to be sent and packet bytes waiting to come out.
   trpf_pkg::req_type quad_queue[$];
   trpf_pkg::rsp_type packet_bytes_due[$];

   // Framer state as the checker sees it.
   logic [7:0]  marker_reg   = trpf_pkg::START_MARKER_RESET;
   logic [7:0]  type_reg     = trpf_pkg::PACKET_TYPE_RESET;
   int unsigned quad_pos     = 0;
   logic [7:0]  crc_acc      = '0;
   logic [7:0]  held_group   = '0;

   // Stimulus bookkeeping and idle control.
   int unsigned queued_pos     = 0;
   int unsigned packets_queued = 0;
   bit          tx_idle_on     = 1'b0;
   bit          rx_idle_on     = 1'b0;
   int          gap_left       = 0;
   int          stall_left     = 0;
   int          mismatch_count = 0;
   int          cycle_count    = 0;

   thermal_row_packet_framer #(
      .PIXEL_COUNT     (PIXEL_COUNT),
      .ROW_WIDTH       (ROW_WIDTH),
      .ROWS_PER_PACKET (ROWS_PER_PACKET)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Reflected CRC-8, processed a whole byte at a time.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] acc;
      acc = crc ^ data;
      repeat (8) acc = acc[0] ? ((acc >> 1) ^ trpf_pkg::CRC_POLY) : (acc >> 1);
      return acc;
   endfunction

   // Queues one expected byte; every byte except the CRC itself feeds the CRC.
   task automatic push_packet_byte(input logic [7:0] value, input logic last);
      trpf_pkg::rsp_type b;
      b.out_byte   = value;
      b.packet_end = last;
      packet_bytes_due.push_back(b);
      if (!last) begin
         crc_acc = crc8_update(crc_acc, value);
      end
   endtask

   // Works out the bytes one accepted quad produces: header on the first quad, packed data, CRC after the last.
   task automatic predict_quad_bytes(input trpf_pkg::req_type q);
      logic [15:0] pix [4];
      logic [9:0]  quot [4];
      logic [39:0] packed_bits;
      int unsigned row;
      int unsigned first_pixel;
      if (quad_pos >= QUADS) quad_pos = 0;
      if (quad_pos == 0) begin
         held_group = q.group_id;
         crc_acc    = '0;
         push_packet_byte(marker_reg, 1'b0);
         push_packet_byte(type_reg, 1'b0);
         push_packet_byte(held_group, 1'b0);
         push_packet_byte(q.frame_seq[7:0], 1'b0);
         push_packet_byte(q.frame_seq[15:8], 1'b0);
      end
      row         = held_group * ROWS_PER_PACKET + quad_pos / QUADS_PER_ROW;
      first_pixel = row * ROW_WIDTH + (quad_pos % QUADS_PER_ROW) * 4;
      pix = '{q.pixel_0, q.pixel_1, q.pixel_2, q.pixel_3};
      // Quads that run past the end of the pixel array go out as zeros.
      for (int k = 0; k < 4; k++) begin
         quot[k] = (first_pixel + 3 >= PIXEL_COUNT) ? 10'd0 : 10'(pix[k] / 5);
      end
      packed_bits = {quot[0], quot[1], quot[2], quot[3]};
      for (int b = 4; b >= 0; b--) begin
         push_packet_byte(packed_bits[b*8 +: 8], 1'b0);
      end
      quad_pos++;
      if (quad_pos >= QUADS) begin
         push_packet_byte(crc_acc, 1'b1);
         quad_pos = 0;
         crc_acc  = '0;
      end
   endtask

   task automatic log_mismatch(input string why, input trpf_pkg::rsp_type want,
                               input trpf_pkg::rsp_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%s: expected byte %02h end %0b, got byte %02h end %0b",
                  why, want.out_byte, want.packet_end, got.out_byte, got.packet_end);
      end
   endtask

   // Register write; the block is idle whenever this is called.
   task automatic csr_write(input logic [trpf_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [7:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         trpf_pkg::CSR_START_MARKER: marker_reg = value;
         trpf_pkg::CSR_PACKET_TYPE:  type_reg   = value;
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Waits until every quad is sent and every expected byte has come out.
   task automatic wait_for_drain();
      do @(negedge clock);
      while (quad_queue.size() != 0 || req_valid || packet_bytes_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Random quads; first quads of a packet rotate over real rows, rows past the
   // array, and any group at all.
   task automatic queue_random_quads(input int count);
      trpf_pkg::req_type q;
      logic [15:0]       pix [4];
      for (int n = 0; n < count; n++) begin
         q.group_id = 8'($urandom_range(0, 255));
         if (queued_pos == 0) begin
            case (packets_queued % 3)
               0: q.group_id = 8'($urandom_range(0, 7));
               1: q.group_id = 8'($urandom_range(8, 255));
               default: ;
            endcase
            packets_queued++;
         end
         q.frame_seq = 16'($urandom_range(0, 65535));
         for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 7))
               0: pix[k] = 16'h0000;
               1: pix[k] = 16'hFFFF;
               2: pix[k] = 16'(5115 + $urandom_range(0, 4));
               3: pix[k] = 16'(5120 + $urandom_range(0, 4));
               default: pix[k] = 16'($urandom_range(0, 65535));
            endcase
         end
         q.pixel_0 = pix[0];
         q.pixel_1 = pix[1];
         q.pixel_2 = pix[2];
         q.pixel_3 = pix[3];
         quad_queue.push_back(q);
         queued_pos = (queued_pos + 1) % QUADS;
      end
   endtask

   // Sender: presents queued quads, holds a stalled word, then idles for the drawn gap.
   always @(posedge clock) begin : quad_driver
      logic              next_valid;
      trpf_pkg::req_type next_data;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         next_valid = req_valid;
         next_data  = req_data;
         if (req_valid && !req_stall) begin
            predict_quad_bytes(req_data);
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (quad_queue.size() > 0) begin
               next_data  = quad_queue.pop_front();
               next_valid = 1'b1;
               gap_left   = tx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            end
         end
         req_valid <= next_valid;
         req_data  <= next_data;
      end
   end

   // Receiver: checks each accepted word against the oldest expected byte.
   always @(posedge clock) begin : byte_monitor
      trpf_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (packet_bytes_due.size() == 0) begin
               want = '0;
               log_mismatch("unexpected word", want, rsp_data);
            end else begin
               want = packet_bytes_due.pop_front();
               if (rsp_data.out_byte !== want.out_byte ||
                   rsp_data.packet_end !== want.packet_end) begin
                  log_mismatch("word mismatch", want, rsp_data);
               end
            end
            stall_left = rx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // Guard against a hung block.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : test_sequence
      trpf_pkg::req_type q;
      logic [15:0]       edge_vals [8];
      edge_vals = '{16'h0000, 16'hFFFF, 16'd4, 16'd5, 16'd5119, 16'd5120,
                    16'hAAAA, 16'h5555};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed packet with reset register values: the last real row group, the
      // largest sequence number, pixel extremes, and header fields on later quads
      // that the block must ignore.
      for (int k = 0; k < QUADS; k++) begin
         q.group_id  = (k == 0) ? 8'd7 : 8'hFF;
         q.frame_seq = (k == 0) ? 16'hFFFF : 16'(k);
         q.pixel_0   = edge_vals[k % 8];
         q.pixel_1   = edge_vals[(k + 1) % 8];
         q.pixel_2   = edge_vals[(k + 2) % 8];
         q.pixel_3   = edge_vals[(k + 3) % 8];
         quad_queue.push_back(q);
      end
      wait_for_drain();

      csr_write(trpf_pkg::CSR_START_MARKER, 8'h00);
      csr_write(trpf_pkg::CSR_PACKET_TYPE, 8'hFF);
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      queue_random_quads(3 * QUADS);
      wait_for_drain();

      // Stop partway into a packet and let it drain; new register values must
      // only appear in the following header.
      csr_write(trpf_pkg::CSR_START_MARKER, 8'hFF);
      csr_write(trpf_pkg::CSR_PACKET_TYPE, 8'h00);
      rx_idle_on = 1'b0;
      queue_random_quads(QUADS + 10);
      wait_for_drain();

      csr_write(trpf_pkg::CSR_START_MARKER, 8'($urandom_range(0, 255)));
      csr_write(trpf_pkg::CSR_PACKET_TYPE, 8'($urandom_range(0, 255)));
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b1;
      queue_random_quads(QUADS - 10 + 2 * QUADS);
      wait_for_drain();

      csr_write(trpf_pkg::CSR_START_MARKER, 8'($urandom_range(0, 255)));
      csr_write(trpf_pkg::CSR_PACKET_TYPE, 8'($urandom_range(0, 255)));
      tx_idle_on = 1'b1;
      queue_random_quads(2 * QUADS);
      wait_for_drain();

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
